// ===== sv/tct_pkg.sv =====
// ----------------------------------------------------------------------------
// tct_pkg
// Shared widths, codes and types for the tcp connection tracker.
// ----------------------------------------------------------------------------
package tct_pkg;

  localparam int unsigned KindW   = 2;
  localparam int unsigned FlagW   = 8;
  localparam int unsigned SeqW    = 32;
  localparam int unsigned LenW    = 16;
  localparam int unsigned OptW    = 6;
  localparam int unsigned StateW  = 4;
  localparam int unsigned WinW    = 16;
  localparam int unsigned HdrW    = 4;
  localparam int unsigned IncrW   = LenW + 1;
  localparam int unsigned HdrSumW = OptW + 1;

  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 16;

  localparam int unsigned QDepth  = 2;
  localparam int unsigned QIdxW   = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  localparam logic [FlagW-1:0] FlFin = 8'h01;
  localparam logic [FlagW-1:0] FlSyn = 8'h02;
  localparam logic [FlagW-1:0] FlPsh = 8'h08;
  localparam logic [FlagW-1:0] FlAck = 8'h10;

  localparam logic [WinW-1:0]    AckWinRst    = 16'd457;
  localparam logic [WinW-1:0]    PlainWinRst  = 16'd14600;
  localparam logic [HdrSumW-1:0] HdrBaseBytes = 7'd20;
  localparam logic [OptW-1:0]    OptMax       = 6'd40;
  localparam logic [HdrW-1:0]    HdrWordsMin  = 4'd5;
  localparam logic [StateW-1:0]  StateMax     = 4'd8;

  typedef enum logic [KindW-1:0] {
    KindRx   = 2'd0,
    KindTx   = 2'd1,
    KindHost = 2'd2,
    KindNone = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAckWin   = 1'b0,
    CfgPlainWin = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OpSyn     = 4'd0,
    OpFinData = 4'd1,
    OpFinCtl  = 4'd2,
    OpAckCtl  = 4'd3,
    OpAckData = 4'd4,
    OpDrop    = 4'd5,
    OpTx      = 4'd6,
    OpHost    = 4'd7,
    OpIdle    = 4'd8
  } op_e;

  typedef struct packed {
    op_e               op;
    logic              fin_ack;
    logic [FlagW-1:0]  flags;
    logic [SeqW-1:0]   seq;
    logic [SeqW-1:0]   ack;
    logic [IncrW-1:0]  incr;
    logic [HdrW-1:0]   hdr_words;
    logic              ns_valid;
    logic [StateW-1:0] new_state;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_port_t;

  typedef struct packed {
    logic              emit_segment;
    logic [SeqW-1:0]   out_seq;
    logic [SeqW-1:0]   out_ack;
    logic [FlagW-1:0]  out_flags;
    logic [WinW-1:0]   out_window;
    logic [HdrW-1:0]   out_hdr_words;
    logic              deliver_payload;
    logic              drop_segment;
    logic [StateW-1:0] conn_state_out;
    logic              state_error;
  } result_t;

endpackage

// ===== sv/tct_if.sv =====
// ----------------------------------------------------------------------------
// tct_if
// Valid/ready channels for segment events and tracker results.
// ----------------------------------------------------------------------------
interface tct_in_if;
  import tct_pkg::*;

  logic              valid;
  logic              ready;
  logic [KindW-1:0]  kind;
  logic [FlagW-1:0]  seg_flags;
  logic [SeqW-1:0]   seq_value;
  logic [SeqW-1:0]   ack_value;
  logic [LenW-1:0]   payload_len;
  logic [OptW-1:0]   option_len;
  logic [StateW-1:0] new_state;

  modport src (
    output valid, kind, seg_flags, seq_value, ack_value, payload_len, option_len,
           new_state,
    input  ready
  );
  modport snk (
    input  valid, kind, seg_flags, seq_value, ack_value, payload_len, option_len,
           new_state,
    output ready
  );
endinterface

interface tct_out_if;
  import tct_pkg::*;

  logic              valid;
  logic              ready;
  logic              emit_segment;
  logic [SeqW-1:0]   out_seq;
  logic [SeqW-1:0]   out_ack;
  logic [FlagW-1:0]  out_flags;
  logic [WinW-1:0]   out_window;
  logic [HdrW-1:0]   out_hdr_words;
  logic              deliver_payload;
  logic              drop_segment;
  logic [StateW-1:0] conn_state_out;
  logic              state_error;

  modport src (
    output valid, emit_segment, out_seq, out_ack, out_flags, out_window, out_hdr_words,
           deliver_payload, drop_segment, conn_state_out, state_error,
    input  ready
  );
  modport snk (
    input  valid, emit_segment, out_seq, out_ack, out_flags, out_window, out_hdr_words,
           deliver_payload, drop_segment, conn_state_out, state_error,
    output ready
  );
endinterface

// ===== sv/tct_front.sv =====
// ----------------------------------------------------------------------------
// tct_front
// Accepts events and classifies them into back-end operations.
// ----------------------------------------------------------------------------
module tct_front (
  tct_in_if.snk             item_i,
  input  logic              q_full_i,
  output tct_pkg::q_port_t  push_o
);
  import tct_pkg::*;

  logic [FlagW-1:0]   flags;
  logic [LenW-1:0]    plen;
  logic [OptW-1:0]    opt_clamp;
  logic [HdrSumW-1:0] hdr_sum;
  logic               is_syn;
  logic               is_fin;
  entry_t             e;

  assign flags     = item_i.seg_flags;
  assign plen      = item_i.payload_len;
  assign opt_clamp = (item_i.option_len > OptMax) ? OptMax : item_i.option_len;
  assign hdr_sum   = HdrBaseBytes + HdrSumW'(opt_clamp);
  assign is_syn    = (flags == FlSyn) || (flags == (FlSyn | FlAck));
  assign is_fin    = (flags == FlFin) || (flags == (FlFin | FlAck)) ||
                     (flags == (FlFin | FlAck | FlPsh));

  always_comb begin
    e           = '0;
    e.op        = OpIdle;
    e.flags     = flags;
    e.fin_ack   = |(flags & FlAck);
    e.seq       = item_i.seq_value;
    e.ack       = item_i.ack_value;
    e.new_state = item_i.new_state;
    e.hdr_words = hdr_sum[HdrW+1:2];
    case (kind_e'(item_i.kind))
      KindRx: begin
        if (is_syn) begin
          e.op   = OpSyn;
          e.incr = IncrW'(1);
        end else if (is_fin) begin
          if (plen != '0) begin
            e.op   = OpFinData;
            e.incr = IncrW'(plen);
          end else begin
            e.op   = OpFinCtl;
            e.incr = IncrW'(1);
          end
        end else if (flags == FlAck && plen == '0) begin
          e.op = OpAckCtl;
        end else if (flags == FlAck || flags == (FlAck | FlPsh)) begin
          e.op   = OpAckData;
          e.incr = IncrW'(plen);
        end else begin
          e.op = OpDrop;
        end
      end
      KindTx: begin
        // syn/fin take one sequence number, psh advances by the payload
        e.op   = OpTx;
        e.incr = IncrW'(|(flags & (FlSyn | FlFin))) +
                 ((|(flags & FlPsh)) ? IncrW'(plen) : IncrW'(0));
      end
      KindHost: begin
        e.op       = OpHost;
        e.ns_valid = (item_i.new_state <= StateMax);
      end
      default: begin
        e.op = OpIdle;
      end
    endcase
  end

  assign item_i.ready = !q_full_i;
  assign push_o.valid = item_i.valid && !q_full_i;
  assign push_o.entry = e;

endmodule

// ===== sv/tct_queue.sv =====
// ----------------------------------------------------------------------------
// tct_queue
// Short fifo between the classifier and the state update stage.
// ----------------------------------------------------------------------------
module tct_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tct_pkg::q_port_t  push_i,
  output logic              full_o,
  input  logic              pop_i,
  output tct_pkg::q_port_t  head_o
);
  import tct_pkg::*;

  entry_t            mem_q [QDepth];
  logic [QIdxW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QIdxW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              push;
  logic              pop;

  assign full_o = (cnt_q == QCntW'(QDepth));
  assign push   = push_i.valid && !full_o;
  assign pop    = pop_i && (cnt_q != '0);

  assign head_o.valid = (cnt_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QIdxW'(QDepth - 1)) ? '0 : wr_ptr_q + QIdxW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QIdxW'(QDepth - 1)) ? '0 : rd_ptr_q + QIdxW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i.valid && full_o))
    else $error("push offered while queue full");

endmodule

// ===== sv/tct_back.sv =====
// ----------------------------------------------------------------------------
// tct_back
// Connection state update, header build and result register.
// ----------------------------------------------------------------------------
module tct_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tct_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tct_pkg::CfgW-1:0]    cfg_wdata_i,
  input  tct_pkg::q_port_t            head_i,
  output logic                        pop_o,
  tct_out_if.src                      result_o
);
  import tct_pkg::*;

  typedef enum logic [StateW-1:0] {
    StClosed      = 4'd0,
    StSynSent     = 4'd1,
    StEstablished = 4'd2,
    StFinWait1    = 4'd3,
    StFinWait2    = 4'd4,
    StClosing     = 4'd5,
    StTimeWait    = 4'd6,
    StCloseWait   = 4'd7,
    StLastAck     = 4'd8
  } conn_state_e;

  conn_state_e       cs_q, cs_d;
  logic [SeqW-1:0]   ls_q, ls_d;
  logic [SeqW-1:0]   ra_q, ra_d;
  logic [WinW-1:0]   ack_win_q, plain_win_q;
  result_t           res_q, res_d;
  logic              res_valid_q;
  entry_t            e;
  logic [SeqW-1:0]   rx_sum;
  logic [SeqW-1:0]   tx_sum;
  logic [FlagW-1:0]  hdr_flags;

  assign e      = head_i.entry;
  assign pop_o  = head_i.valid && (!res_valid_q || result_o.ready);
  assign rx_sum = e.seq + SeqW'(e.incr);
  assign tx_sum = ls_q + SeqW'(e.incr);

  always_comb begin
    cs_d      = cs_q;
    ls_d      = ls_q;
    ra_d      = ra_q;
    hdr_flags = FlAck;
    res_d     = '0;
    res_d.out_hdr_words = HdrWordsMin;
    case (e.op)
      OpSyn: begin
        ra_d               = rx_sum;
        res_d.emit_segment = 1'b1;
        res_d.drop_segment = 1'b1;
        if (cs_q == StSynSent) begin
          cs_d = StEstablished;
        end else begin
          res_d.state_error = 1'b1;
        end
      end
      OpFinData, OpAckData: begin
        ra_d                  = rx_sum;
        res_d.emit_segment    = 1'b1;
        res_d.deliver_payload = 1'b1;
      end
      OpFinCtl: begin
        ra_d               = rx_sum;
        res_d.emit_segment = 1'b1;
        res_d.drop_segment = 1'b1;
        case (cs_q)
          StFinWait1:    cs_d = e.fin_ack ? StTimeWait : StClosing;
          StFinWait2:    cs_d = StTimeWait;
          StEstablished: cs_d = StCloseWait;
          default:       res_d.state_error = 1'b1;
        endcase
      end
      OpAckCtl: begin
        res_d.drop_segment = 1'b1;
        case (cs_q)
          StFinWait1: cs_d = StFinWait2;
          StClosing:  cs_d = StTimeWait;
          StLastAck:  cs_d = StClosed;
          default:    cs_d = cs_q;
        endcase
      end
      OpDrop: begin
        res_d.drop_segment = 1'b1;
      end
      OpTx: begin
        hdr_flags           = e.flags;
        ls_d                = tx_sum;
        res_d.emit_segment  = 1'b1;
        res_d.out_hdr_words = e.hdr_words;
      end
      OpHost: begin
        ls_d = e.seq;
        ra_d = e.ack;
        if (e.ns_valid) begin
          cs_d = conn_state_e'(e.new_state);
        end
      end
      default: begin
        cs_d = cs_q;
      end
    endcase
    // header carries the local number before any advance and the updated ack
    if (res_d.emit_segment) begin
      res_d.out_seq    = ls_q;
      res_d.out_ack    = ra_d;
      res_d.out_flags  = hdr_flags;
      res_d.out_window = (|(hdr_flags & FlAck)) ? ack_win_q : plain_win_q;
      if (e.op != OpTx) begin
        res_d.out_hdr_words = HdrWordsMin;
      end
    end
    res_d.conn_state_out = cs_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q        <= StClosed;
      ls_q        <= '0;
      ra_q        <= '0;
      ack_win_q   <= AckWinRst;
      plain_win_q <= PlainWinRst;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgAckWin:   ack_win_q   <= cfg_wdata_i;
          CfgPlainWin: plain_win_q <= cfg_wdata_i;
          default:     ack_win_q   <= ack_win_q;
        endcase
      end
      if (pop_o) begin
        cs_q        <= cs_d;
        ls_q        <= ls_d;
        ra_q        <= ra_d;
        res_q       <= res_d;
        res_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign result_o.valid           = res_valid_q;
  assign result_o.emit_segment    = res_q.emit_segment;
  assign result_o.out_seq         = res_q.out_seq;
  assign result_o.out_ack         = res_q.out_ack;
  assign result_o.out_flags       = res_q.out_flags;
  assign result_o.out_window      = res_q.out_window;
  assign result_o.out_hdr_words   = res_q.out_hdr_words;
  assign result_o.deliver_payload = res_q.deliver_payload;
  assign result_o.drop_segment    = res_q.drop_segment;
  assign result_o.conn_state_out  = res_q.conn_state_out;
  assign result_o.state_error     = res_q.state_error;

  a_deliver_xor_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> !(res_q.deliver_payload && res_q.drop_segment))
    else $error("segment both delivered and dropped");

  a_idle_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.emit_segment) |->
      (res_q.out_hdr_words == HdrWordsMin && res_q.out_flags == '0))
    else $error("idle result carries header fields");

  a_error_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.state_error) |-> res_q.drop_segment)
    else $error("state error on a segment that was not dropped");

  a_stall_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !result_o.ready) |-> !pop_o)
    else $error("state advanced while result stalled");

endmodule

// ===== sv/tcp_connection_tracker_unit.sv =====
// An input transfer is registered in the queue, then in the result register, before its result can transfer.
// Throughput: one item per cycle while results are taken; the state update in the back stage sets it.
// A 2-entry queue takes up to two more items while a result is stalled, then input stalls.
// Reset (rst_ni low, asynchronous): state CLOSED, local and ack numbers zero,
// windows 457 and 14600, queue and result register empty. Usable the cycle after release.
// ----------------------------------------------------------------------------
// tcp_connection_tracker_unit
// Tracks one tcp connection: classifier, queue and state update stage.
// ----------------------------------------------------------------------------
module tcp_connection_tracker_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tct_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tct_pkg::CfgW-1:0]    cfg_wdata_i,
  tct_in_if.snk                       item_i,
  tct_out_if.src                      result_o
);
  import tct_pkg::*;

  q_port_t push;
  q_port_t head;
  logic    q_full;
  logic    pop;

  tct_front u_front (
    .item_i   (item_i),
    .q_full_i (q_full),
    .push_o   (push)
  );

  tct_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .pop_i  (pop),
    .head_o (head)
  );

  tct_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (head),
    .pop_o       (pop),
    .result_o    (result_o)
  );

endmodule

// ===== bench/tcp_connection_tracker_unit_tb.sv =====
// ----------------------------------------------------------------------------
// tcp_connection_tracker_unit_tb
// Drives segment events into the connection tracker and checks every result
// against an in-bench model of the connection state, the sequence numbers and
// the emitted header fields. Directed corner cases come first, then random
// connection lifecycles mixed with noise, under several window settings, with
// random stalls on both channels.
// ----------------------------------------------------------------------------
module tcp_connection_tracker_unit_tb;
  import tct_pkg::*;

  localparam logic [StateW-1:0] StClosed      = 4'd0;
  localparam logic [StateW-1:0] StSynSent     = 4'd1;
  localparam logic [StateW-1:0] StEstablished = 4'd2;
  localparam logic [StateW-1:0] StFinWait1    = 4'd3;
  localparam logic [StateW-1:0] StFinWait2    = 4'd4;
  localparam logic [StateW-1:0] StClosing     = 4'd5;
  localparam logic [StateW-1:0] StTimeWait    = 4'd6;
  localparam logic [StateW-1:0] StCloseWait   = 4'd7;
  localparam logic [StateW-1:0] StLastAck     = 4'd8;

  localparam logic [FlagW-1:0] FlRst = 8'h04;
  localparam logic [FlagW-1:0] FlUrg = 8'h20;

  localparam int unsigned RandomItems = 450;
  localparam int unsigned NumPhases   = 4;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned SettleCycles = 6;

  typedef struct packed {
    kind_e             kind;
    logic [FlagW-1:0]  flags;
    logic [SeqW-1:0]   seq;
    logic [SeqW-1:0]   ack;
    logic [LenW-1:0]   plen;
    logic [OptW-1:0]   opt;
    logic [StateW-1:0] new_state;
  } seg_event_t;

  class tracker_scoreboard;
    logic [WinW-1:0]   ack_win;
    logic [WinW-1:0]   plain_win;
    logic [StateW-1:0] conn;
    logic [SeqW-1:0]   local_seq;
    logic [SeqW-1:0]   remote_ack;
    result_t           awaited_results[$];
    int unsigned       mismatches;
    int unsigned       strays;
    int unsigned       reports;
    int unsigned       checked;
    logic [15:0]       states_seen;

    function new();
      ack_win     = AckWinRst;
      plain_win   = PlainWinRst;
      conn        = StClosed;
      local_seq   = '0;
      remote_ack  = '0;
      mismatches  = 0;
      strays      = 0;
      reports     = 0;
      checked     = 0;
      states_seen = '0;
    endfunction

    function void set_windows(logic [WinW-1:0] ack_w, logic [WinW-1:0] plain_w);
      ack_win   = ack_w;
      plain_win = plain_w;
    endfunction

    function int unsigned outstanding();
      return awaited_results.size();
    endfunction

    function result_t header(logic [FlagW-1:0] fl, logic [HdrW-1:0] words);
      result_t r;
      r               = '0;
      r.emit_segment  = 1'b1;
      r.out_seq       = local_seq;
      r.out_ack       = remote_ack;
      r.out_flags     = fl;
      r.out_window    = ((fl & FlAck) != 0) ? ack_win : plain_win;
      r.out_hdr_words = words;
      return r;
    endfunction

    function result_t track_receive(seg_event_t ev);
      result_t r;
      logic    fin_data;
      r = '0;
      r.out_hdr_words = HdrWordsMin;
      if (ev.flags == FlSyn || ev.flags == (FlSyn | FlAck)) begin
        remote_ack = ev.seq + 32'd1;
        r = header(FlAck, HdrWordsMin);
        r.drop_segment = 1'b1;
        if (conn == StSynSent) conn = StEstablished;
        else r.state_error = 1'b1;
      end else if (ev.flags == FlFin || ev.flags == (FlFin | FlAck) ||
                   ev.flags == (FlFin | FlAck | FlPsh)) begin
        fin_data   = (ev.plen != 0);
        remote_ack = fin_data ? ev.seq + ev.plen : ev.seq + 32'd1;
        r = header(FlAck, HdrWordsMin);
        if (fin_data) begin
          r.deliver_payload = 1'b1;
        end else begin
          r.drop_segment = 1'b1;
          if (conn == StFinWait1) conn = ((ev.flags & FlAck) != 0) ? StTimeWait : StClosing;
          else if (conn == StFinWait2) conn = StTimeWait;
          else if (conn == StEstablished) conn = StCloseWait;
          else r.state_error = 1'b1;
        end
      end else if (ev.flags == FlAck && ev.plen == 0) begin
        r.drop_segment = 1'b1;
        if (conn == StFinWait1) conn = StFinWait2;
        else if (conn == StClosing) conn = StTimeWait;
        else if (conn == StLastAck) conn = StClosed;
      end else if (ev.flags == FlAck || ev.flags == (FlAck | FlPsh)) begin
        remote_ack = ev.seq + ev.plen;
        r = header(FlAck, HdrWordsMin);
        r.deliver_payload = 1'b1;
      end else begin
        r.drop_segment = 1'b1;
      end
      return r;
    endfunction

    function result_t track_event(seg_event_t ev);
      result_t          r;
      logic [OptW-1:0]  opt;
      logic [OptW:0]    hdr_bytes;
      r = '0;
      r.out_hdr_words = HdrWordsMin;
      case (ev.kind)
        KindRx: begin
          r = track_receive(ev);
        end
        KindTx: begin
          opt       = (ev.opt > OptMax) ? OptMax : ev.opt;
          hdr_bytes = HdrBaseBytes + {1'b0, opt};
          r = header(ev.flags, hdr_bytes[OptW-1:2]);
          if ((ev.flags & (FlSyn | FlFin)) != 0) local_seq = local_seq + 32'd1;
          if ((ev.flags & FlPsh) != 0) local_seq = local_seq + ev.plen;
        end
        KindHost: begin
          if (ev.new_state <= StateMax) conn = ev.new_state;
          local_seq  = ev.seq;
          remote_ack = ev.ack;
        end
        default: ;
      endcase
      r.conn_state_out = conn;
      return r;
    endfunction

    function void note_event(seg_event_t ev);
      awaited_results.push_back(track_event(ev));
    endfunction

    function string show(result_t r);
      return $sformatf("emit=%0b seq=%h ack=%h flags=%h win=%0d words=%0d dlv=%0b drop=%0b st=%0d err=%0b",
                       r.emit_segment, r.out_seq, r.out_ack, r.out_flags, r.out_window,
                       r.out_hdr_words, r.deliver_payload, r.drop_segment, r.conn_state_out,
                       r.state_error);
    endfunction

    function void check_result(result_t got);
      result_t want;
      string   diff;
      if (awaited_results.size() == 0) begin
        strays++;
        reports++;
        if (reports <= 10) $display("unexpected result with nothing pending: %s", show(got));
        return;
      end
      want = awaited_results.pop_front();
      checked++;
      states_seen[want.conn_state_out] = 1'b1;
      diff = "";
      if (got.emit_segment    !== want.emit_segment)    diff = {diff, " emit_segment"};
      if (got.out_seq         !== want.out_seq)         diff = {diff, " out_seq"};
      if (got.out_ack         !== want.out_ack)         diff = {diff, " out_ack"};
      if (got.out_flags       !== want.out_flags)       diff = {diff, " out_flags"};
      if (got.out_window      !== want.out_window)      diff = {diff, " out_window"};
      if (got.out_hdr_words   !== want.out_hdr_words)   diff = {diff, " out_hdr_words"};
      if (got.deliver_payload !== want.deliver_payload) diff = {diff, " deliver_payload"};
      if (got.drop_segment    !== want.drop_segment)    diff = {diff, " drop_segment"};
      if (got.conn_state_out  !== want.conn_state_out)  diff = {diff, " conn_state_out"};
      if (got.state_error     !== want.state_error)     diff = {diff, " state_error"};
      if (diff != "") begin
        mismatches++;
        reports++;
        if (reports <= 10) begin
          $display("mismatch on result %0d:%s", checked, diff);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgW-1:0]     cfg_wdata_i;

  tct_in_if  item_if ();
  tct_out_if result_if ();

  tcp_connection_tracker_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_if),
    .result_o    (result_if)
  );

  tracker_scoreboard sb;
  bit                hold_req;
  int unsigned       items_sent;
  int unsigned       input_stalls;
  int unsigned       settings_used;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAIL tcp_connection_tracker_unit");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 2);
    if (p < 96) return $urandom_range(3, 8);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [LenW-1:0] plen_pick();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 15) return '0;
    if (p < 85) return LenW'($urandom_range(1, 1460));
    if (p < 95) return LenW'($urandom_range(1461, 65534));
    return '1;
  endfunction

  function automatic logic [OptW-1:0] opt_pick();
    if ($urandom_range(0, 3) == 0) return OptW'($urandom_range(0, 63));
    return OptW'(4 * $urandom_range(0, 10));
  endfunction

  function automatic logic [FlagW-1:0] flags_pick();
    case ($urandom_range(0, 9))
      0: return FlSyn;
      1: return FlSyn | FlAck;
      2: return FlFin;
      3: return FlFin | FlAck;
      4: return FlFin | FlAck | FlPsh;
      5: return FlAck;
      6: return FlAck | FlPsh;
      default: return FlagW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic seg_event_t mk(kind_e k, logic [FlagW-1:0] fl, logic [SeqW-1:0] s,
                                    logic [SeqW-1:0] a, logic [LenW-1:0] pl,
                                    logic [OptW-1:0] op, logic [StateW-1:0] ns);
    seg_event_t ev;
    ev.kind      = k;
    ev.flags     = fl;
    ev.seq       = s;
    ev.ack       = a;
    ev.plen      = pl;
    ev.opt       = op;
    ev.new_state = ns;
    return ev;
  endfunction

  // unused fields carry random junk so that every input bit toggles
  function automatic seg_event_t rx(logic [FlagW-1:0] fl, logic [LenW-1:0] pl);
    return mk(KindRx, fl, $urandom, $urandom, pl, opt_pick(), StateW'($urandom_range(0, 15)));
  endfunction

  function automatic seg_event_t tx(logic [FlagW-1:0] fl, logic [LenW-1:0] pl);
    return mk(KindTx, fl, $urandom, $urandom, pl, opt_pick(), StateW'($urandom_range(0, 15)));
  endfunction

  function automatic seg_event_t host(logic [StateW-1:0] ns);
    return mk(KindHost, FlagW'($urandom_range(0, 255)), $urandom, $urandom, plen_pick(),
              opt_pick(), ns);
  endfunction

  function automatic seg_event_t noise_event();
    return mk(kind_e'($urandom_range(0, 3)), flags_pick(), $urandom, $urandom, plen_pick(),
              OptW'($urandom_range(0, 63)), StateW'($urandom_range(0, 15)));
  endfunction

  function automatic result_t sample_result();
    result_t r;
    r.emit_segment    = result_if.emit_segment;
    r.out_seq         = result_if.out_seq;
    r.out_ack         = result_if.out_ack;
    r.out_flags       = result_if.out_flags;
    r.out_window      = result_if.out_window;
    r.out_hdr_words   = result_if.out_hdr_words;
    r.deliver_payload = result_if.deliver_payload;
    r.drop_segment    = result_if.drop_segment;
    r.conn_state_out  = result_if.conn_state_out;
    r.state_error     = result_if.state_error;
    return r;
  endfunction

  // called right after a rising edge; returns at the edge of the transfer
  task automatic send(seg_event_t ev);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid       <= 1'b1;
    item_if.kind        <= ev.kind;
    item_if.seg_flags   <= ev.flags;
    item_if.seq_value   <= ev.seq;
    item_if.ack_value   <= ev.ack;
    item_if.payload_len <= ev.plen;
    item_if.option_len  <= ev.opt;
    item_if.new_state   <= ev.new_state;
    @(posedge clk_i);
    while (item_if.ready !== 1'b1) begin
      input_stalls++;
      @(posedge clk_i);
    end
    sb.note_event(ev);
    items_sent++;
  endtask

  task automatic maybe_noise();
    if ($urandom_range(0, 9) == 0) send(noise_event());
  endtask

  // one connection from open to close, with random data in between
  task automatic run_connection();
    int unsigned n;
    send(host(StSynSent));
    maybe_noise();
    send(tx(FlSyn, plen_pick()));
    if ($urandom_range(0, 9) != 0) send(rx($urandom_range(0, 1) ? (FlSyn | FlAck) : FlSyn, '0));
    maybe_noise();
    n = $urandom_range(1, 6);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: send(rx(FlAck, plen_pick()));
        1: send(rx(FlAck | FlPsh, plen_pick()));
        2: send(tx(FlAck | FlPsh, plen_pick()));
        default: send(rx(FlFin | FlAck | FlPsh, LenW'($urandom_range(1, 1460))));
      endcase
      maybe_noise();
    end
    case ($urandom_range(0, 3))
      0: begin
        send(tx(FlFin | FlAck, '0));
        send(host(StFinWait1));
        send(rx(FlAck, '0));
        maybe_noise();
        send(rx(FlFin | FlAck, '0));
      end
      1: begin
        send(host(StFinWait1));
        send(rx(FlFin, '0));
        maybe_noise();
        send(rx(FlAck, '0));
      end
      2: begin
        send(host(StFinWait1));
        send(rx(FlFin | FlAck, '0));
      end
      default: begin
        send(rx(FlFin, '0));
        send(tx(FlFin | FlAck, '0));
        send(host(StLastAck));
        maybe_noise();
        send(rx(FlAck, '0));
      end
    endcase
  endtask

  // drop valid, drain outstanding results, then let the pipeline settle
  task automatic wait_idle();
    item_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_windows(logic [WinW-1:0] ack_w, logic [WinW-1:0] plain_w);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgAckWin;
    cfg_wdata_i <= ack_w;
    @(posedge clk_i);
    cfg_idx_i   <= CfgPlainWin;
    cfg_wdata_i <= plain_w;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_windows(ack_w, plain_w);
    settings_used++;
  endtask

  // result side: random ready runs, plus one long hold-off on request
  initial begin : result_sink
    bit          rdy;
    int unsigned run;
    int unsigned gap;
    rdy = 1'b1;
    run = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (result_if.valid === 1'b1 && result_if.ready === 1'b1) sb.check_result(sample_result());
      if (run == 0) begin
        if (hold_req) begin
          hold_req = 1'b0;
          rdy = 1'b0;
          run = HoldCycles;
        end else if (!rdy) begin
          rdy = 1'b1;
          run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
        end else begin
          gap = idle_gap();
          if (gap == 0) begin
            run = $urandom_range(1, 20);
          end else begin
            rdy = 1'b0;
            run = gap;
          end
        end
      end
      run--;
      result_if.ready <= rdy;
    end
  end

  initial begin : stimulus
    logic [WinW-1:0] ack_settings [NumPhases];
    logic [WinW-1:0] plain_settings [NumPhases];
    int unsigned     target;
    int unsigned     failures;

    sb            = new();
    hold_req      = 1'b0;
    items_sent    = 0;
    input_stalls  = 0;
    settings_used = 1;
    ack_settings   = '{16'h0000, 16'hFFFF, WinW'($urandom), 16'h0001};
    plain_settings = '{16'hFFFF, 16'h0000, WinW'($urandom), 16'hFFFE};

    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= CfgAckWin;
    cfg_wdata_i         <= '0;
    item_if.valid       <= 1'b0;
    item_if.kind        <= KindRx;
    item_if.seg_flags   <= '0;
    item_if.seq_value   <= '0;
    item_if.ack_value   <= '0;
    item_if.payload_len <= '0;
    item_if.option_len  <= '0;
    item_if.new_state   <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner cases under the reset windows
    send(mk(KindHost, 8'h00, 32'hFFFF_FFF0, 32'h0, 16'h0, 6'd0, StSynSent));
    send(mk(KindTx, FlSyn, 32'h0, 32'h0, 16'hFFFF, 6'd40, StClosed));
    send(mk(KindRx, FlSyn | FlAck, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0, 6'd0, StClosed));
    send(mk(KindRx, FlSyn, 32'h1234_5678, 32'h0, 16'h0, 6'd63, 4'hF));
    send(mk(KindRx, FlAck, 32'hFFFF_FF00, 32'h0, 16'hFFFF, 6'd0, StClosed));
    send(mk(KindRx, FlAck | FlPsh, 32'h0000_0000, 32'h0, 16'h0, 6'd0, StClosed));
    send(mk(KindTx, FlAck | FlPsh, 32'h0, 32'h0, 16'hFFFF, 6'd63, StClosed));
    send(mk(KindTx, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h1, 6'd0, 4'hF));
    send(mk(KindTx, FlUrg | FlAck, 32'h0, 32'h0, 16'h5, 6'd41, StClosed));
    send(mk(KindRx, FlRst, 32'hDEAD_BEEF, 32'h0, 16'h10, 6'd0, StClosed));
    send(mk(KindRx, FlFin | FlAck | FlPsh, 32'h0000_1000, 32'h0, 16'd100, 6'd0, StClosed));
    send(mk(KindRx, FlFin, 32'h0000_2000, 32'h0, 16'h0, 6'd0, StClosed));
    send(mk(KindHost, 8'h00, 32'h100, 32'h200, 16'h0, 6'd0, StFinWait1));
    send(mk(KindRx, FlFin, 32'h300, 32'h0, 16'h0, 6'd0, StClosed));
    send(mk(KindRx, FlAck, 32'h0, 32'h0, 16'h0, 6'd0, StClosed));
    send(mk(KindHost, 8'h00, 32'h400, 32'h500, 16'h0, 6'd0, StFinWait1));
    send(mk(KindRx, FlFin | FlAck, 32'h600, 32'h0, 16'h0, 6'd0, StClosed));
    send(mk(KindHost, 8'h00, 32'h700, 32'h800, 16'h0, 6'd0, StFinWait1));
    send(mk(KindRx, FlAck, 32'h900, 32'h0, 16'h0, 6'd0, StClosed));
    send(mk(KindRx, FlFin, 32'hA00, 32'h0, 16'h0, 6'd0, StClosed));
    send(mk(KindRx, FlFin, 32'hB00, 32'h0, 16'h0, 6'd0, StClosed));
    // out-of-range host state keeps the state but takes the numbers
    send(mk(KindHost, 8'hFF, 32'h0, 32'hFFFF_FFFF, 16'hFFFF, 6'd63, 4'hF));
    send(mk(KindHost, 8'h00, 32'hC00, 32'hD00, 16'h0, 6'd0, StLastAck));
    send(mk(KindRx, FlAck, 32'h0, 32'h0, 16'h0, 6'd0, StClosed));
    send(mk(KindNone, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 6'd63, 4'hF));
    send(mk(KindRx, FlAck, 32'h0, 32'h0, 16'h0, 6'd0, StClosed));

    target = items_sent;
    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      write_windows(ack_settings[p], plain_settings[p]);
      if (p == 1) hold_req = 1'b1;
      target += RandomItems / NumPhases;
      while (items_sent < target) begin
        if ($urandom_range(0, 9) < 7) begin
          run_connection();
        end else begin
          repeat ($urandom_range(1, 5)) send(noise_event());
        end
      end
    end

    wait_idle();
    failures = sb.mismatches + sb.strays + sb.outstanding();
    $display("run covered %0d segment events, %0d results checked, %0d window settings",
             items_sent, sb.checked, settings_used);
    $display("connection states reached (bit per state): %b, input stall cycles: %0d",
             sb.states_seen[StateMax:0], input_stalls);
    if (failures == 0) begin
      $display("PASS tcp_connection_tracker_unit");
    end else begin
      $display("%0d mismatches, %0d unexpected results, %0d missing results",
               sb.mismatches, sb.strays, sb.outstanding());
      $display("FAIL tcp_connection_tracker_unit");
    end
    $finish;
  end

endmodule
